// ===== sv/oal_pkg.sv =====
// ----------------------------------------------------------------------------
// oal_pkg: shared types and codes for the ordered array list engine
// Holds the action and status codes and the command and status structs
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package oal_pkg;

  // Field widths of the transaction payloads.
  localparam int ACT_W    = 3;
  localparam int POS_W    = 9;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int FIDX_W   = 8;
  localparam int LEN_W    = 9;

  // Action codes carried on the input channel.
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

  // Status codes carried on the result channel.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_REM_SHIFT,
    S_SRCH,
    S_RD_WAIT,
    S_FINISH
  } state_t;

  // Which result the datapath should record.
  typedef enum logic [2:0] {
    RES_OK,
    RES_RANGE,
    RES_FULL,
    RES_NOT_FOUND,
    RES_FOUND,
    RES_READ
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted input transaction
    logic ptr_ins;    // walk pointer starts at the list length
    logic ptr_rem;    // walk pointer starts one past the position
    logic ptr_zero;   // walk pointer starts at zero
    logic step_up;    // move entry ptr-1 to ptr, pointer down
    logic step_dn;    // move entry ptr to ptr-1, pointer up
    logic srch_step;  // read entry ptr for compare, pointer up
    logic rd_pos;     // read the entry at the position
    logic put;        // write the value at the position
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic res_set;    // record the result selected by res_sel
    res_t res_sel;
    logic out_load;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             pos_gt_cnt;
    logic             pos_ge_cnt;
    logic             full;
    logic             ptr_gt_pos;
    logic             ptr_lt_cnt;
    logic             cmp_pend;
    logic             match;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/oal_in_if.sv =====
// ----------------------------------------------------------------------------
// oal_in_if: input channel of the ordered array list engine
// Valid/ready channel carrying one list action per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface oal_in_if;
  import oal_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [POS_W-1:0] position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output action, output position, output value,
                  input ready);
  modport sink   (input valid, input action, input position, input value,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/oal_out_if.sv =====
// ----------------------------------------------------------------------------
// oal_out_if: result channel of the ordered array list engine
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface oal_out_if;
  import oal_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [FIDX_W-1:0] found_index;
  logic signed [VAL_W-1:0] read_value;
  logic [LEN_W-1:0]  list_length;

  modport source (output valid, output status, output found_index,
                  output read_value, output list_length, input ready);
  modport sink   (input valid, input status, input found_index,
                  input read_value, input list_length, output ready);
endinterface

`default_nettype wire

// ===== sv/ordered_array_list_engine_top.sv =====
// Insert and remove shift the entries one at a time, search scans from entry
// zero until a hit or the end of the list, read waits on the registered memory
// read, and clear, unused and rejected actions go straight to the finish state.
// One transaction is in work at a time; a new action is accepted only after
// the result of the last one has been loaded into the output register.
// Reset clears the length and control state; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// ordered_array_list_engine_top: packed list with insert, remove and search
// Joins the controller and the datapath to the input and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_list_engine_top #(
  parameter int CAPACITY = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  oal_in_if.sink    in_ch,
  oal_out_if.source out_ch
);
  import oal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of each transaction.
  oal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage, walk and result registers.
  oal_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_ch.action),
    .in_position     (in_ch.position),
    .in_value        (in_ch.value),
    .out_status      (out_ch.status),
    .out_found_index (out_ch.found_index),
    .out_read_value  (out_ch.read_value),
    .out_list_length (out_ch.list_length)
  );

endmodule

`default_nettype wire

// ===== sv/oal_ctrl.sv =====
// ----------------------------------------------------------------------------
// oal_ctrl: controller of the ordered array list engine
// State machine that sequences each action over the datapath and owns the
// input ready and the output valid of the transaction channels.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  output      logic          out_valid,
  input  wire logic          out_ready,
  input  wire oal_pkg::sts_t sts,
  output      oal_pkg::cmd_t cmd
);
  import oal_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The output register can take a new result when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        case (sts.act)
          ACT_INSERT: begin
            if (sts.pos_gt_cnt || sts.full) state_nxt = S_FINISH;
            else                            state_nxt = S_INS_SHIFT;
          end
          ACT_REMOVE: begin
            if (sts.pos_ge_cnt) state_nxt = S_FINISH;
            else                state_nxt = S_REM_SHIFT;
          end
          ACT_SEARCH: state_nxt = S_SRCH;
          ACT_READ: begin
            if (sts.pos_ge_cnt) state_nxt = S_FINISH;
            else                state_nxt = S_RD_WAIT;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_INS_SHIFT: begin
        if (!sts.ptr_gt_pos) state_nxt = S_INS_PUT;
      end
      S_INS_PUT:   state_nxt = S_FINISH;
      S_REM_SHIFT: begin
        if (!sts.ptr_lt_cnt) state_nxt = S_FINISH;
      end
      S_SRCH: begin
        if (sts.match || (!sts.ptr_lt_cnt && !sts.cmp_pend)) state_nxt = S_FINISH;
      end
      S_RD_WAIT: state_nxt = S_FINISH;
      S_FINISH: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd         = '0;
    cmd.res_sel = RES_OK;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_DECIDE: begin
        case (sts.act)
          ACT_INSERT: begin
            if (sts.pos_gt_cnt) begin
              cmd.res_set = 1'b1;
              cmd.res_sel = RES_RANGE;
            end else if (sts.full) begin
              cmd.res_set = 1'b1;
              cmd.res_sel = RES_FULL;
            end else begin
              cmd.ptr_ins = 1'b1;
            end
          end
          ACT_REMOVE: begin
            if (sts.pos_ge_cnt) begin
              cmd.res_set = 1'b1;
              cmd.res_sel = RES_RANGE;
            end else begin
              cmd.ptr_rem = 1'b1;
            end
          end
          ACT_SEARCH: cmd.ptr_zero = 1'b1;
          ACT_READ: begin
            if (sts.pos_ge_cnt) begin
              cmd.res_set = 1'b1;
              cmd.res_sel = RES_RANGE;
            end else begin
              cmd.rd_pos = 1'b1;
            end
          end
          ACT_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            cmd.res_set = 1'b1;
          end
          default: cmd.res_set = 1'b1;
        endcase
      end
      S_INS_SHIFT: begin
        cmd.step_up = sts.ptr_gt_pos;
      end
      S_INS_PUT: begin
        cmd.put     = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.res_set = 1'b1;
      end
      S_REM_SHIFT: begin
        if (sts.ptr_lt_cnt) begin
          cmd.step_dn = 1'b1;
        end else begin
          cmd.cnt_dec = 1'b1;
          cmd.res_set = 1'b1;
        end
      end
      S_SRCH: begin
        if (sts.match) begin
          cmd.res_set = 1'b1;
          cmd.res_sel = RES_FOUND;
        end else if (sts.ptr_lt_cnt) begin
          cmd.srch_step = 1'b1;
        end else if (!sts.cmp_pend) begin
          cmd.res_set = 1'b1;
          cmd.res_sel = RES_NOT_FOUND;
        end
      end
      S_RD_WAIT: begin
        cmd.res_set = 1'b1;
        cmd.res_sel = RES_READ;
      end
      S_FINISH: begin
        cmd.out_load = slot_free;
      end
      default: cmd.load = 1'b0;
    endcase
  end

  // Output valid follows loads and drains of the output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)           out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/oal_dpath.sv =====
// ----------------------------------------------------------------------------
// oal_dpath: datapath of the ordered array list engine
// Entry memory with one write and one registered read port, the length
// counter, the walk pointer, the search comparator and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_dpath #(
  parameter int CAPACITY = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire oal_pkg::cmd_t                cmd,
  output      oal_pkg::sts_t                sts,
  input  wire logic [oal_pkg::ACT_W-1:0]    in_action,
  input  wire logic [oal_pkg::POS_W-1:0]    in_position,
  input  wire logic signed [oal_pkg::VAL_W-1:0] in_value,
  output      logic [oal_pkg::STAT_W-1:0]   out_status,
  output      logic [oal_pkg::FIDX_W-1:0]   out_found_index,
  output      logic signed [oal_pkg::VAL_W-1:0] out_read_value,
  output      logic [oal_pkg::LEN_W-1:0]    out_list_length
);
  import oal_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > POS_W) ? CW : POS_W;
  localparam int IW = (CW > FIDX_W) ? CW : FIDX_W;
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;

  logic [VAL_W-1:0] mem [CAPACITY];

  // Captured transaction.
  logic [ACT_W-1:0] act_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic [VAL_W-1:0] rdata_r;
  logic             wpend_r;
  logic [AW-1:0]    waddr_r;
  logic             cmp_pend_r;
  logic [CW-1:0]    cmp_idx_r;

  logic [STAT_W-1:0] res_stat_r;
  logic [CW-1:0]     res_idx_r;
  logic [VAL_W-1:0]  res_val_r;

  logic [EW-1:0] pos_e, cnt_e, ptr_e, pos_p1, ptr_m1_e;
  logic [AW-1:0] pos_addr, ptr_addr, ptr_m1_addr_w;
  logic [CW-1:0] ptr_m1, ptr_p1;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [VAL_W-1:0] wr_data;
  logic [IW-1:0] idx_e;
  logic [LW-1:0] len_e;

  // Extended operands for the range compares.
  assign pos_e  = EW'(pos_r);
  assign cnt_e  = EW'(cnt_r);
  assign ptr_e  = EW'(ptr_r);
  assign pos_p1 = pos_e + EW'(1);
  assign ptr_m1 = ptr_r - CW'(1);
  assign ptr_p1 = ptr_r + CW'(1);
  assign pos_addr    = pos_e[AW-1:0];
  assign ptr_addr    = ptr_e[AW-1:0];

  assign ptr_m1_e      = EW'(ptr_m1);
  assign ptr_m1_addr_w = ptr_m1_e[AW-1:0];

  // Status toward the controller.
  always_comb begin
    sts.act        = act_r;
    sts.pos_gt_cnt = (pos_e > cnt_e);
    sts.pos_ge_cnt = (pos_e >= cnt_e);
    sts.full       = (cnt_e >= EW'(CAPACITY));
    sts.ptr_gt_pos = (ptr_e > pos_e);
    sts.ptr_lt_cnt = (ptr_r < cnt_r);
    sts.cmp_pend   = cmp_pend_r;
    sts.match      = cmp_pend_r && (rdata_r == val_r);
  end

  // Memory port selection. A pending shift write always drains first.
  always_comb begin
    wr_en   = wpend_r || cmd.put;
    wr_addr = wpend_r ? waddr_r : pos_addr;
    wr_data = wpend_r ? rdata_r : val_r;
    rd_en   = cmd.step_up || cmd.step_dn || cmd.srch_step || cmd.rd_pos;
    if (cmd.step_up)     rd_addr = ptr_m1_addr_w;
    else if (cmd.rd_pos) rd_addr = pos_addr;
    else                 rd_addr = ptr_addr;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // Walk pointer.
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_ins)                        ptr_nxt = cnt_r;
    else if (cmd.ptr_rem)                   ptr_nxt = pos_p1[CW-1:0];
    else if (cmd.ptr_zero)                  ptr_nxt = '0;
    else if (cmd.step_up)                   ptr_nxt = ptr_m1;
    else if (cmd.step_dn || cmd.srch_step)  ptr_nxt = ptr_p1;
  end

  // Length counter.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr)      cnt_nxt = '0;
    else if (cmd.cnt_inc) cnt_nxt = cnt_r + CW'(1);
    else if (cmd.cnt_dec) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      wpend_r    <= 1'b0;
      cmp_pend_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      wpend_r    <= cmd.step_up || cmd.step_dn;
      cmp_pend_r <= cmd.srch_step;
    end
  end

  // Walk registers and captured transaction fields.
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.step_up)        waddr_r <= ptr_addr;
    else if (cmd.step_dn)   waddr_r <= ptr_m1_addr_w;
    if (cmd.srch_step)      cmp_idx_r <= ptr_r;
    if (cmd.load) begin
      act_r <= in_action;
      pos_r <= in_position;
      val_r <= in_value;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      case (cmd.res_sel)
        RES_RANGE: begin
          res_stat_r <= ST_RANGE;
          res_idx_r  <= '0;
          res_val_r  <= '0;
        end
        RES_FULL: begin
          res_stat_r <= ST_FULL;
          res_idx_r  <= '0;
          res_val_r  <= '0;
        end
        RES_NOT_FOUND: begin
          res_stat_r <= ST_NOT_FOUND;
          res_idx_r  <= '0;
          res_val_r  <= '0;
        end
        RES_FOUND: begin
          res_stat_r <= ST_OK;
          res_idx_r  <= cmp_idx_r;
          res_val_r  <= '0;
        end
        RES_READ: begin
          res_stat_r <= ST_OK;
          res_idx_r  <= '0;
          res_val_r  <= rdata_r;
        end
        default: begin
          res_stat_r <= ST_OK;
          res_idx_r  <= '0;
          res_val_r  <= '0;
        end
      endcase
    end
  end

  // Output register, loaded after the length has settled.
  assign idx_e = IW'(res_idx_r);
  assign len_e = LW'(cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status      <= res_stat_r;
      out_found_index <= idx_e[FIDX_W-1:0];
      out_read_value  <= res_val_r;
      out_list_length <= len_e[LEN_W-1:0];
    end
  end

endmodule

`default_nettype wire
